FILE: rtl/rst_pkg.sv
package rst_pkg;

  localparam int SESSION_COUNT = 1024;
  localparam int ID_BYTES      = 8;
  localparam int IDX_W         = (SESSION_COUNT > 1) ? $clog2(SESSION_COUNT) : 1;
  localparam int CNT_W         = $clog2(SESSION_COUNT + 1);

  localparam logic [63:0] ID_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - 8 * ID_BYTES);

  localparam logic [15:0] TIMEOUT_RESET = 16'd120;
  localparam logic [15:0] DELAY_RESET   = 16'd200;

  localparam logic [2:0] OP_HELLO = 3'd0;
  localparam logic [2:0] OP_KEEP  = 3'd1;
  localparam logic [2:0] OP_DATA  = 3'd2;
  localparam logic [2:0] OP_BYE   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [2:0] KIND_ACK   = 3'd0;
  localparam logic [2:0] KIND_INFO  = 3'd1;
  localparam logic [2:0] KIND_FWD   = 3'd2;
  localparam logic [2:0] KIND_DROP  = 3'd3;
  localparam logic [2:0] KIND_SFULL = 3'd4;
  localparam logic [2:0] KIND_TFULL = 3'd5;

  typedef struct packed {
    logic        v;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] seen;
  } slot_t;

  typedef struct packed {
    logic        sv;
    logic [63:0] key;
    slot_t       s0;
    slot_t       s1;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] dip;
    logic [15:0] dport;
    logic [31:0] aip;
    logic [15:0] aport;
    logic [15:0] delay;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] delay;
  } cfg_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [31:0] dip, logic [15:0] dport,
                                  logic [31:0] aip, logic [15:0] aport, logic [15:0] delay);
    res_t r;
    r.kind  = kind;
    r.dip   = dip;
    r.dport = dport;
    r.aip   = aip;
    r.aport = aport;
    r.delay = delay;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/rst_ram.sv
module rst_ram import rst_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [SESSION_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/rst_out.sv
module rst_out import rst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  res_t        push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res
);

  res_t       q [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       pop;

  assign full      = (count == 3'd4);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = q[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + {2'd0, push && !full} - {2'd0, pop};
    end
  end

endmodule

FILE: rtl/rst_ctrl.sv
module rst_ctrl import rst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic        header_ok,
  input  logic [63:0] meeting_id,
  input  logic [31:0] source_ip,
  input  logic [15:0] source_port,
  output logic        push,
  output res_t        push_data,
  input  logic        fifo_full
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SESSION_COUNT);

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] pidx;

  logic [2:0]  op;
  logic [63:0] key;
  logic [31:0] ip;
  logic [15:0] port;
  logic [31:0] now;

  logic             found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_ent;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  res_t       r0, r1, r2;
  logic [1:0] rcnt;
  logic [1:0] rptr;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  logic   accept;
  logic   issue;
  entry_t base, e_en, e_bye, swept;
  logic   m0, m1, en_ok, have;
  logic   alive0, alive1;
  logic   x_wr;
  entry_t x_data;
  res_t   x_r0, x_r1, x_r2;
  logic [1:0] x_n;
  res_t   sel;

  rst_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state == ST_SCAN || state == ST_SWEEP) && (cnt != CNT_END);
  assign rd_en    = issue;
  assign rd_addr  = cnt[IDX_W-1:0];

  always_comb begin
    base = hit_ent;
    if (!found) begin
      base     = '0;
      base.sv  = 1'b1;
      base.key = key;
    end
    have = found || (op == OP_HELLO && free_found);
    m0 = base.s0.v && base.s0.ip == ip && base.s0.port == port;
    m1 = base.s1.v && base.s1.ip == ip && base.s1.port == port;
    e_en  = base;
    en_ok = 1'b1;
    if (m0) begin
      e_en.s0.seen = now;
    end else if (m1) begin
      e_en.s1.seen = now;
    end else if (!base.s0.v) begin
      e_en.s0 = '{v: 1'b1, ip: ip, port: port, seen: now};
    end else if (!base.s1.v) begin
      e_en.s1 = '{v: 1'b1, ip: ip, port: port, seen: now};
    end else begin
      en_ok = 1'b0;
    end
    e_bye = base;
    if (m0) begin
      e_bye.s0.v = 1'b0;
    end
    if (m1) begin
      e_bye.s1.v = 1'b0;
    end
    if (!e_bye.s0.v && !e_bye.s1.v) begin
      e_bye.sv = 1'b0;
    end

    x_wr   = 1'b0;
    x_data = e_en;
    x_n    = 2'd1;
    x_r0   = mk_res(KIND_DROP, '0, '0, '0, '0, '0);
    x_r1   = x_r0;
    x_r2   = x_r0;
    case (op)
      OP_HELLO: begin
        if (!have) begin
          x_r0 = mk_res(KIND_TFULL, '0, '0, '0, '0, '0);
        end else if (!en_ok) begin
          x_r0 = mk_res(KIND_SFULL, '0, '0, '0, '0, '0);
        end else begin
          x_wr = 1'b1;
          x_r0 = mk_res(KIND_ACK, ip, port, ip, port, '0);
          if (e_en.s0.v && e_en.s1.v) begin
            x_n  = 2'd3;
            x_r1 = mk_res(KIND_INFO, e_en.s0.ip, e_en.s0.port, e_en.s1.ip, e_en.s1.port,
                          cfg.delay);
            x_r2 = mk_res(KIND_INFO, e_en.s1.ip, e_en.s1.port, e_en.s0.ip, e_en.s0.port,
                          cfg.delay);
          end
        end
      end
      OP_KEEP: begin
        if (found && en_ok) begin
          x_wr = 1'b1;
          x_n  = 2'd0;
        end
      end
      OP_DATA: begin
        if (found && (m0 || m1)) begin
          if (!m0 && base.s0.v) begin
            x_r0 = mk_res(KIND_FWD, base.s0.ip, base.s0.port, '0, '0, '0);
          end else if (!m1 && base.s1.v) begin
            x_r0 = mk_res(KIND_FWD, base.s1.ip, base.s1.port, '0, '0, '0);
          end
        end
      end
      default: begin
        if (found) begin
          x_wr   = 1'b1;
          x_data = e_bye;
          x_n    = 2'd0;
        end
      end
    endcase
  end

  always_comb begin
    swept  = rd_data;
    alive0 = rd_data.s0.v && ((now - rd_data.s0.seen) <= {16'd0, cfg.timeout});
    alive1 = rd_data.s1.v && ((now - rd_data.s1.seen) <= {16'd0, cfg.timeout});
    if (rd_data.sv) begin
      swept.s0.v = alive0;
      swept.s1.v = alive1;
      swept.sv   = alive0 || alive1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pidx;
    wr_data = swept;
    case (state)
      ST_CLEAR: begin
        wr_en   = (cnt != CNT_END);
        wr_addr = cnt[IDX_W-1:0];
        wr_data = '0;
      end
      ST_SWEEP: begin
        wr_en = pend;
      end
      ST_EXEC: begin
        wr_en   = x_wr;
        wr_addr = found ? hit_idx : free_idx;
        wr_data = x_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (rptr)
      2'd0:    sel = r0;
      2'd1:    sel = r1;
      default: sel = r2;
    endcase
    push_data      = sel;
    push_data.last = (rptr == rcnt - 2'd1);
    push           = (state == ST_EMIT) && !fifo_full;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= operation;
      key  <= meeting_id & ID_MASK;
      ip   <= source_ip;
      port <= source_port;
    end
    if (state == ST_SCAN && pend && !found && rd_data.sv && rd_data.key == key) begin
      hit_idx <= pidx;
      hit_ent <= rd_data;
    end
    if (state == ST_SCAN && pend && !free_found && !rd_data.sv) begin
      free_idx <= pidx;
    end
    if (accept) begin
      r0 <= mk_res(KIND_DROP, '0, '0, '0, '0, '0);
    end else if (state == ST_EXEC) begin
      r0 <= x_r0;
      r1 <= x_r1;
      r2 <= x_r2;
    end
    pidx <= cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      pend       <= 1'b0;
      now        <= 32'd0;
      found      <= 1'b0;
      free_found <= 1'b0;
      rcnt       <= 2'd0;
      rptr       <= 2'd0;
    end else begin
      pend <= issue;
      case (state)
        ST_CLEAR: begin
          if (cnt == CNT_END) begin
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          cnt        <= '0;
          found      <= 1'b0;
          free_found <= 1'b0;
          rptr       <= 2'd0;
          if (accept) begin
            if (!header_ok || operation > OP_TICK) begin
              rcnt  <= 2'd1;
              state <= ST_EMIT;
            end else if (operation == OP_TICK) begin
              now   <= now + 32'd1;
              state <= ST_SWEEP;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (pend && rd_data.sv && rd_data.key == key) begin
            found <= 1'b1;
          end
          if (pend && !rd_data.sv) begin
            free_found <= 1'b1;
          end
          if (!issue && !pend) begin
            state <= ST_EXEC;
          end
        end
        ST_SWEEP: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (!issue && !pend) begin
            state <= ST_IDLE;
          end
        end
        ST_EXEC: begin
          rcnt  <= x_n;
          state <= (x_n == 2'd0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (push) begin
            rptr <= rptr + 2'd1;
            if (rptr == rcnt - 2'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !wr_en) else $error("write during lookup scan");
  a_push_emit: assert property (@(posedge clk) disable iff (rst)
    push |-> state == ST_EMIT && rcnt != 2'd0) else $error("push outside emit");
  a_exec_next: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> state == ST_EMIT || state == ST_IDLE) else $error("bad exec exit");
  a_sweep_rw: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP && wr_en && rd_en |-> wr_addr != rd_addr) else $error("sweep overlap");

endmodule

FILE: rtl/rendezvous_session_table.sv
// Hello, keepalive, data and bye scan the whole session memory, one entry per
// cycle, before any result is produced.
// Tick sweeps every entry by read-modify-write.
// Bad header or unknown operation: drop result, emitted without a memory scan.
// Input stalls until the previous transaction is done; results leave through a 4-deep queue.
// Reset: a clearing pass empties the session memory; no input taken.
module rendezvous_session_table import rst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic        header_ok,
  input  logic [63:0] meeting_id,
  input  logic [31:0] source_ip,
  input  logic [15:0] source_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  message_kind,
  output logic [31:0] dest_ip,
  output logic [15:0] dest_port,
  output logic [31:0] about_ip,
  output logic [15:0] about_port,
  output logic [15:0] delay_millis,
  output logic        last
);

  cfg_t cfg;
  logic push;
  res_t push_data;
  logic fifo_full;
  res_t out_res;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'd0, cfg.delay} : {16'd0, cfg.timeout};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout <= TIMEOUT_RESET;
      cfg.delay   <= DELAY_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        cfg.delay <= pwdata[15:0];
      end else begin
        cfg.timeout <= pwdata[15:0];
      end
    end
  end

  rst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .header_ok   (header_ok),
    .meeting_id  (meeting_id),
    .source_ip   (source_ip),
    .source_port (source_port),
    .push        (push),
    .push_data   (push_data),
    .fifo_full   (fifo_full)
  );

  rst_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign message_kind = out_res.kind;
  assign dest_ip      = out_res.dip;
  assign dest_port    = out_res.dport;
  assign about_ip     = out_res.aip;
  assign about_port   = out_res.aport;
  assign delay_millis = out_res.delay;
  assign last         = out_res.last;

endmodule

FILE: verif/rst_checker.sv
`timescale 1ns / 100ps
module rst_checker import rst_pkg::*; #(
  parameter logic [2:0] ADDR_TIMEOUT = 3'd0,
  parameter logic [2:0] ADDR_DELAY   = 3'd4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  operation,
  input  logic        header_ok,
  input  logic [63:0] meeting_id,
  input  logic [31:0] source_ip,
  input  logic [15:0] source_port,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  message_kind,
  input  logic [31:0] dest_ip,
  input  logic [15:0] dest_port,
  input  logic [31:0] about_ip,
  input  logic [15:0] about_port,
  input  logic [15:0] delay_millis,
  input  logic        last,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);

  logic [15:0] timeout_s;
  logic [15:0] punch_delay;
  logic        sess_used [SESSION_COUNT];
  logic [63:0] sess_id   [SESSION_COUNT];
  logic        peer_used [2*SESSION_COUNT];
  logic [31:0] peer_ip   [2*SESSION_COUNT];
  logic [15:0] member_port [2*SESSION_COUNT];
  logic [31:0] peer_seen [2*SESSION_COUNT];
  logic [31:0] clock_s;
  res_t        expected_msgs [$];

  assign outstanding = expected_msgs.size();

  function automatic int lookup_sess(logic [63:0] key);
    for (int i = 0; i < SESSION_COUNT; i++) begin
      if (sess_used[i] && sess_id[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic bit is_member(int q, logic [31:0] ip, logic [15:0] port);
    return peer_used[q] && peer_ip[q] == ip && member_port[q] == port;
  endfunction

  function automatic int join_peer(int s, logic [31:0] ip, logic [15:0] port);
    for (int p = 0; p < 2; p++) begin
      if (is_member(2*s+p, ip, port)) begin
        peer_seen[2*s+p] = clock_s;
        return 2*s+p;
      end
    end
    for (int p = 0; p < 2; p++) begin
      if (!peer_used[2*s+p]) begin
        peer_used[2*s+p]   = 1'b1;
        peer_ip[2*s+p]     = ip;
        member_port[2*s+p] = port;
        peer_seen[2*s+p]   = clock_s;
        return 2*s+p;
      end
    end
    return -1;
  endfunction

  function automatic res_t msg(logic [2:0] kind, logic [31:0] dip, logic [15:0] dport,
                               logic [31:0] aip, logic [15:0] aport, logic [15:0] dly);
    res_t r;
    r.kind = kind; r.dip = dip; r.dport = dport;
    r.aip = aip; r.aport = aport; r.delay = dly; r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_session(logic [2:0] op, logic ok, logic [63:0] raw_id,
                                 logic [31:0] ip, logic [15:0] port);
    res_t        outs [$];
    logic [63:0] key;
    int          s, a, b, dst;
    bit          known, alive;
    key = raw_id & ID_MASK;
    if (!ok || op > OP_TICK) begin
      outs.push_back(msg(KIND_DROP, '0, '0, '0, '0, '0));
    end else if (op == OP_TICK) begin
      clock_s = clock_s + 32'd1;
      for (int i = 0; i < SESSION_COUNT; i++) begin
        if (sess_used[i]) begin
          alive = 0;
          for (int p = 0; p < 2; p++) begin
            if (peer_used[2*i+p]) begin
              if (clock_s - peer_seen[2*i+p] > {16'd0, timeout_s}) peer_used[2*i+p] = 1'b0;
              else alive = 1;
            end
          end
          if (!alive) sess_used[i] = 1'b0;
        end
      end
    end else begin
      s = lookup_sess(key);
      case (op)
        OP_HELLO: begin
          if (s < 0) begin
            for (int i = 0; i < SESSION_COUNT; i++) begin
              if (!sess_used[i]) begin
                s = i;
                break;
              end
            end
            if (s >= 0) begin
              sess_used[s] = 1'b1;
              sess_id[s] = key;
              peer_used[2*s] = 1'b0;
              peer_used[2*s+1] = 1'b0;
            end
          end
          if (s < 0) outs.push_back(msg(KIND_TFULL, '0, '0, '0, '0, '0));
          else if (join_peer(s, ip, port) < 0)
            outs.push_back(msg(KIND_SFULL, '0, '0, '0, '0, '0));
          else begin
            a = 2*s; b = 2*s+1;
            outs.push_back(msg(KIND_ACK, ip, port, ip, port, '0));
            if (peer_used[a] && peer_used[b]) begin
              outs.push_back(msg(KIND_INFO, peer_ip[a], member_port[a], peer_ip[b],
                                 member_port[b], punch_delay));
              outs.push_back(msg(KIND_INFO, peer_ip[b], member_port[b], peer_ip[a],
                                 member_port[a], punch_delay));
            end
          end
        end
        OP_KEEP: begin
          if (s < 0) outs.push_back(msg(KIND_DROP, '0, '0, '0, '0, '0));
          else if (join_peer(s, ip, port) < 0)
            outs.push_back(msg(KIND_DROP, '0, '0, '0, '0, '0));
        end
        OP_DATA: begin
          dst = -1; known = 0;
          if (s >= 0) begin
            for (int p = 0; p < 2; p++) begin
              if (is_member(2*s+p, ip, port)) known = 1;
              else if (peer_used[2*s+p] && dst < 0) dst = 2*s+p;
            end
          end
          if (dst >= 0 && known)
            outs.push_back(msg(KIND_FWD, peer_ip[dst], member_port[dst], '0, '0, '0));
          else outs.push_back(msg(KIND_DROP, '0, '0, '0, '0, '0));
        end
        default: begin
          if (s < 0) outs.push_back(msg(KIND_DROP, '0, '0, '0, '0, '0));
          else begin
            for (int p = 0; p < 2; p++) begin
              if (is_member(2*s+p, ip, port)) peer_used[2*s+p] = 1'b0;
            end
            if (!peer_used[2*s] && !peer_used[2*s+1]) sess_used[s] = 1'b0;
          end
        end
      endcase
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[k]) expected_msgs.push_back(outs[k]);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      timeout_s = TIMEOUT_RESET;
      punch_delay = DELAY_RESET;
      clock_s = '0;
      for (int i = 0; i < SESSION_COUNT; i++) sess_used[i] = 1'b0;
      for (int i = 0; i < 2*SESSION_COUNT; i++) peer_used[i] = 1'b0;
      expected_msgs.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_TIMEOUT) timeout_s = pwdata[15:0];
        else if (paddr == ADDR_DELAY) punch_delay = pwdata[15:0];
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_msgs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected result kind %0d", $time, message_kind);
        end else begin
          want = expected_msgs.pop_front();
          if (want.kind !== message_kind || want.dip !== dest_ip || want.dport !== dest_port ||
              want.aip !== about_ip || want.aport !== about_port ||
              want.delay !== delay_millis || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp k%0d d%h:%h a%h:%h dl%0d l%b got k%0d d%h:%h a%h:%h dl%0d l%b",
                       $time, want.kind, want.dip, want.dport, want.aip, want.aport, want.delay,
                       want.last, message_kind, dest_ip, dest_port, about_ip, about_port,
                       delay_millis, last);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_session(operation, header_ok, meeting_id, source_ip, source_port);
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import rst_pkg::*;

  localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
  localparam logic [2:0] ADDR_DELAY   = 3'd4;
  localparam int QUIET_LIMIT = 50000;
  localparam int DRAIN_CYCLES = SESSION_COUNT + 100;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0, in_stall;
  logic [2:0]  operation = 0;
  logic        header_ok = 0;
  logic [63:0] meeting_id = 0;
  logic [31:0] source_ip = 0;
  logic [15:0] source_port = 0;
  logic        out_valid, out_stall = 0;
  logic [2:0]  message_kind;
  logic [31:0] dest_ip, about_ip;
  logic [15:0] dest_port, about_port, delay_millis;
  logic        last;

  int mismatches, outstanding, results_seen;
  int send_idle = 0, recv_idle = 0;
  int sent = 0, quiet = 0;
  bit hold_on = 0;
  logic [63:0] id_pool [4];
  logic [31:0] ip_pool [4];
  logic [15:0] port_pool [4];

  always #1 clk = ~clk;

  rendezvous_session_table i_dut (.*);

  rst_checker #(.ADDR_TIMEOUT(ADDR_TIMEOUT), .ADDR_DELAY(ADDR_DELAY)) i_checker (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall = hold_on || ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_packet(logic [2:0] op, logic ok, logic [63:0] id,
                             logic [31:0] ip, logic [15:0] port);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1; operation = op; header_ok = ok; meeting_id = id;
    source_ip = ip; source_port = port;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel = 1; pwrite = 1; penable = 0; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic settle_and_config(logic [15:0] tmo, logic [15:0] dly);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_write(ADDR_TIMEOUT, {16'd0, tmo});
    apb_write(ADDR_DELAY, {16'd0, dly});
  endtask

  task automatic random_traffic(int count);
    int r, ki, ai;
    logic [2:0]  op;
    logic        ok;
    logic [63:0] id;
    logic [31:0] ip;
    logic [15:0] port;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      ok = 1'b1;
      if (r < 35) op = OP_HELLO;
      else if (r < 50) op = OP_KEEP;
      else if (r < 75) op = OP_DATA;
      else if (r < 85) op = OP_BYE;
      else if (r < 94) op = OP_TICK;
      else if (r < 97) begin
        op = 3'($urandom_range(7));
        ok = 1'b0;
      end else op = 3'($urandom_range(7, 5));
      ki = $urandom_range(3);
      ai = $urandom_range(3);
      id = ($urandom_range(99) < 8) ? {$urandom, $urandom} : id_pool[ki];
      ip = ($urandom_range(99) < 8) ? $urandom : ip_pool[ai];
      port = ($urandom_range(99) < 8) ? 16'($urandom) : port_pool[ai];
      send_packet(op, ok, id, ip, port);
    end
  endtask

  task automatic hold_output(int cycles);
    hold_on = 1;
    repeat (cycles) @(negedge clk);
    hold_on = 0;
  endtask

  initial begin
    logic [63:0] k1, k2;
    logic [31:0] ipc;
    for (int i = 0; i < 4; i++) begin
      id_pool[i] = {$urandom, $urandom};
      ip_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    k1 = 64'hFFFF_FFFF_FFFF_FFFF;
    k2 = 64'h0;
    ipc = 32'h0A00_0001;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_idle = 21; recv_idle = 51;
    send_packet(OP_HELLO, 1'b1, k1, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_HELLO, 1'b1, k1, 32'h0, 16'h0);
    send_packet(OP_HELLO, 1'b1, k1, ipc, 16'd5000);
    send_packet(OP_HELLO, 1'b1, k1, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_KEEP, 1'b1, k1, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_KEEP, 1'b1, k1, ipc, 16'd5000);
    send_packet(OP_KEEP, 1'b1, k2, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_DATA, 1'b1, k1, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_DATA, 1'b1, k1, ipc, 16'd5000);
    send_packet(OP_DATA, 1'b1, k2, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_BYE, 1'b1, k1, ipc, 16'd5000);
    send_packet(OP_BYE, 1'b1, k1, 32'h0, 16'h0);
    send_packet(OP_DATA, 1'b1, k1, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_KEEP, 1'b1, k1, ipc, 16'd5000);
    send_packet(OP_BYE, 1'b1, k1, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_BYE, 1'b1, k1, ipc, 16'd5000);
    send_packet(OP_BYE, 1'b1, k1, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(OP_HELLO, 1'b0, k1, ipc, 16'd5000);
    for (int op = 5; op < 8; op++) send_packet(3'(op), 1'b1, k2, ipc, 16'd7);
    send_packet(OP_TICK, 1'b0, k2, 32'd0, 16'd0);
    send_packet(OP_TICK, 1'b1, k2, 32'd0, 16'd0);
    send_packet(OP_HELLO, 1'b1, k2, ipc, 16'd5000);

    settle_and_config(16'd0, 16'hFFFF);
    random_traffic(40);

    settle_and_config(16'hFFFF, 16'd0);
    send_idle = 51; recv_idle = 21;
    random_traffic(40);

    settle_and_config(16'd3, 16'($urandom));
    send_idle = 0; recv_idle = 0;
    fork
      hold_output(8000);
      random_traffic(40);
    join

    settle_and_config(16'd0, 16'd200);
    send_packet(OP_TICK, 1'b1, 64'd0, 32'd0, 16'd0);
    send_packet(OP_HELLO, 1'b1, k2, ipc, 16'd1);

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Drove %0d transactions: every operation, bad headers, expiry, full sessions,",
             sent);
    $display("long output back-pressure; %0d results compared under five timeout/delay pairs.",
             results_seen);
    if (mismatches == 0 && outstanding == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
